[hw/rtl/cbm_pkg.sv]
// ----------------------------------------------------------------------------
// cbm_pkg: shared types, constants and helpers of the cartridge bank mapper
// Address decode codes, register indexes and the bank wrap functions.
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam int ADDR_W         = 16;
	localparam int DATA_W         = 8;
	localparam int ROM_ADDR_W     = 21;
	localparam int ROM_BANK_W     = 7;
	localparam int LOW_BANK_W     = 5;
	localparam int UPPER_W        = 2;
	localparam int RAM_BANK_W     = 2;
	localparam int RAM_BANKS      = 4;
	localparam int RAM_BANK_BYTES = 8192;
	localparam int RAM_OFF_W      = $clog2(RAM_BANK_BYTES);
	localparam int RAM_DEPTH      = RAM_BANKS * RAM_BANK_BYTES;
	localparam int RAM_IDX_W      = $clog2(RAM_DEPTH);
	localparam int ROM_OFF_W      = 14;
	localparam int CFG_W          = 3;
	localparam int CFG_INDEX_W    = 1;

	localparam logic [DATA_W-1:0] BYTE_FF       = 8'hFF;
	localparam logic [3:0]        RAM_EN_KEY    = 4'hA;
	localparam logic [CFG_INDEX_W-1:0] REG_ROM_SIZE  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_RAM_COUNT = 1'b1;

	typedef enum logic [2:0] {
		REG_RAM_ENABLE = 3'b000,
		REG_ROM_BANK   = 3'b001,
		REG_UPPER      = 3'b010,
		REG_MODE       = 3'b011,
		ROM_SWITCH_LO  = 3'b100,
		ROM_SWITCH_HI  = 3'b101,
		UNMAPPED       = 3'b110,
		CART_RAM       = 3'b111
	} region_t;

	function automatic region_t decode_region(input logic [ADDR_W-1:0] addr);
		region_t r;
		r = UNMAPPED;
		case (addr[15:13])
			3'b000: r = REG_RAM_ENABLE;
			3'b001: r = REG_ROM_BANK;
			3'b010: r = REG_UPPER;
			3'b011: r = REG_MODE;
			3'b101: r = CART_RAM;
			default: r = UNMAPPED;
		endcase
		return r;
	endfunction

	function automatic logic [ROM_BANK_W-1:0] rom_bank_mask(input logic [CFG_W-1:0] code);
		logic [ROM_BANK_W-1:0] m;
		m = '1;
		case (code)
			3'd0: m = 7'h01;
			3'd1: m = 7'h03;
			3'd2: m = 7'h07;
			3'd3: m = 7'h0F;
			3'd4: m = 7'h1F;
			3'd5: m = 7'h3F;
			default: m = 7'h7F;
		endcase
		return m;
	endfunction

	function automatic logic [RAM_BANK_W-1:0] ram_bank_wrap(input logic [RAM_BANK_W-1:0] d,
	                                                        input logic [CFG_W-1:0] count);
		logic [RAM_BANK_W-1:0] r;
		r = d;
		case (count)
			3'd1: r = '0;
			3'd2: r = {1'b0, d[0]};
			3'd3: r = (d == 2'd3) ? 2'd0 : d;
			default: r = d;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/cbm_if.sv]
// ----------------------------------------------------------------------------
// cbm_if: valid/ready channels of the cartridge bank mapper
// One channel for bus accesses and one for their results.
// ----------------------------------------------------------------------------
interface cbm_access_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source (output valid, mode, address, write_data, input ready);
	modport sink   (input valid, mode, address, write_data, output ready);
endinterface

interface cbm_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic        rom_hit;
	logic [20:0] rom_address;

	modport source (output valid, read_data, rom_hit, rom_address, input ready);
	modport sink   (input valid, read_data, rom_hit, rom_address, output ready);
endinterface

[hw/rtl/cartridge_bank_mapper.sv]
// ----------------------------------------------------------------------------
// cartridge_bank_mapper: banked ROM/RAM cartridge controller
// Decodes CPU bus accesses, updates the banking registers and serves the
// 32 KiB cartridge RAM; ROM reads give the physical ROM address.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                              | accepted when
//  ----------+-----+--------------------------------------+----------------
//  accesses  | in  | mode, address, write_data            | valid && ready
//  results   | out | read_data, rom_hit, rom_address      | valid && ready
//  cfg       | in  | cfg_we, cfg_index, cfg_wdata         | cfg_we
//
// One item per cycle sustained unless results stall; a result passes stage one,
// where the single-port RAM is read, then the output register. Registers update
// at acceptance, so the next item sees them at once. A stalled result holds in
// the output register while one more item waits in stage one. No clearing pass.
module cartridge_bank_mapper (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cbm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cbm_pkg::CFG_W-1:0]    cfg_wdata,
	cbm_access_if.sink                   accesses,
	cbm_result_if.source                 results
);
	import cbm_pkg::*;

	logic [ROM_BANK_W-1:0] rom_bank_q;
	logic [UPPER_W-1:0]    upper_q;
	logic [RAM_BANK_W-1:0] ram_bank_q;
	logic                  ram_enabled_q;
	logic                  banking_mode_q;
	logic [CFG_W-1:0]      rom_size_q;
	logic [CFG_W-1:0]      ram_count_q;

	logic [DATA_W-1:0]     ram_mem [RAM_DEPTH];
	logic [DATA_W-1:0]     ram_rdata_q;

	logic                  valid_s1;
	logic                  use_ram_s1;
	logic [DATA_W-1:0]     rd_const_s1;
	logic                  hit_s1;
	logic [ROM_ADDR_W-1:0] rom_addr_s1;

	logic                  out_valid_q;
	logic [DATA_W-1:0]     out_rd_q;
	logic                  out_hit_q;
	logic [ROM_ADDR_W-1:0] out_addr_q;

	logic                  accept;
	logic                  advance;
	logic                  wr;
	region_t               region;
	logic [RAM_IDX_W-1:0]  ram_idx;
	logic                  ram_we;
	logic                  ram_re;
	logic [LOW_BANK_W-1:0] low_bank;
	logic                  rd_use_ram;
	logic [DATA_W-1:0]     rd_const;
	logic                  rd_hit;
	logic [ROM_ADDR_W-1:0] rd_addr;

	assign advance        = valid_s1 && (!out_valid_q || results.ready);
	assign accesses.ready = !valid_s1 || advance;
	assign accept         = accesses.valid && accesses.ready;
	assign wr             = accesses.mode;
	assign region         = decode_region(accesses.address);
	assign ram_idx        = {ram_bank_q, accesses.address[RAM_OFF_W-1:0]};
	assign ram_we         = accept && wr && (region == CART_RAM) && ram_enabled_q;
	assign ram_re         = accept && !wr && (region == CART_RAM) && ram_enabled_q;
	assign low_bank       = (accesses.write_data[LOW_BANK_W-1:0] == '0) ?
	                        LOW_BANK_W'(1) : accesses.write_data[LOW_BANK_W-1:0];

	always_comb begin
		rd_use_ram = 1'b0;
		rd_const   = '0;
		rd_hit     = 1'b0;
		rd_addr    = '0;
		if (!wr) begin
			case (region)
				REG_RAM_ENABLE, REG_ROM_BANK: begin
					rd_hit  = 1'b1;
					rd_addr = ROM_ADDR_W'(accesses.address[ROM_OFF_W-1:0]);
				end
				REG_UPPER, REG_MODE: begin
					rd_hit  = 1'b1;
					rd_addr = {rom_bank_q, accesses.address[ROM_OFF_W-1:0]};
				end
				CART_RAM: begin
					rd_use_ram = ram_enabled_q;
					rd_const   = BYTE_FF;
				end
				default: rd_const = BYTE_FF;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_size_q  <= '0;
			ram_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROM_SIZE:  rom_size_q  <= cfg_wdata;
				REG_RAM_COUNT: ram_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q     <= ROM_BANK_W'(1);
			upper_q        <= '0;
			ram_bank_q     <= '0;
			ram_enabled_q  <= 1'b0;
			banking_mode_q <= 1'b0;
		end else if (accept && wr) begin
			case (region)
				REG_RAM_ENABLE: ram_enabled_q <= (accesses.write_data[3:0] == RAM_EN_KEY);
				REG_ROM_BANK: rom_bank_q <= {upper_q, low_bank} & rom_bank_mask(rom_size_q);
				REG_UPPER: begin
					if (!banking_mode_q) begin
						upper_q <= accesses.write_data[UPPER_W-1:0];
					end else if (ram_count_q != '0) begin
						ram_bank_q <= ram_bank_wrap(accesses.write_data[RAM_BANK_W-1:0],
						                            ram_count_q);
					end
				end
				REG_MODE: begin
					if (!accesses.write_data[0]) begin
						banking_mode_q <= 1'b0;
						ram_bank_q     <= '0;
					end else begin
						banking_mode_q <= 1'b1;
						upper_q        <= '0;
						rom_bank_q     <= rom_bank_q & ROM_BANK_W'(7'h1F);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			ram_mem[ram_idx] <= accesses.write_data;
		end
		if (ram_re) begin
			ram_rdata_q <= ram_mem[ram_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accesses.ready) begin
			valid_s1 <= accesses.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			use_ram_s1  <= rd_use_ram;
			rd_const_s1 <= rd_const;
			hit_s1      <= rd_hit;
			rom_addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_rd_q   <= use_ram_s1 ? ram_rdata_q : rd_const_s1;
			out_hit_q  <= hit_s1;
			out_addr_q <= rom_addr_s1;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.read_data   = out_rd_q;
	assign results.rom_hit     = out_hit_q;
	assign results.rom_address = out_addr_q;

endmodule

[hw/rtl/cbm_checker.sv]
// ----------------------------------------------------------------------------
// cbm_checker: port-level checks of the cartridge bank mapper
// Watches the two channels and the result fields over time.
// ----------------------------------------------------------------------------
module cbm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  read_data,
	input logic        rom_hit,
	input logic [20:0] rom_address
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_rom_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rom_hit |-> read_data == 8'h00)
		else $error("ROM read carries nonzero data");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rom_hit |-> rom_address == 21'h0)
		else $error("non-ROM result carries a ROM address");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result item without a matching accepted item");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (accesses.valid),
	.in_ready    (accesses.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.read_data   (results.read_data),
	.rom_hit     (results.rom_hit),
	.rom_address (results.rom_address)
);
